// ----- rtl/inverse_covariance_3d_assert.svh -----
// Assertion macros for the inverse covariance RTL.
// Users need clk and rst_n in scope; no other dependencies.
`ifndef INVERSE_COVARIANCE_3D_ASSERT_SVH
`define INVERSE_COVARIANCE_3D_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IC3_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IC3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ic3_pkg.sv -----
// Shared types, constants and the scatter/adjugate program for inverse_covariance_3d.
// No dependencies.
`default_nettype none

package ic3_pkg;

  localparam int DEF_MAX_SAMPLES = 4096;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int WIDE_BITS       = 256;
  localparam int FRAC_W          = 6;
  localparam int JOB_QUEUE_DEPTH = 2;

  localparam logic [FRAC_W-1:0] FRAC_RESET = 6'd16;
  localparam logic [FRAC_W-1:0] FRAC_MAX   = 6'd32;

  typedef logic [WIDE_BITS-1:0] wide_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FEW    = 2'd1,
    ST_NOT_PD = 2'd2
  } status_t;

  // Operand sources of the shared multiply-accumulate unit.
  typedef enum logic [4:0] {
    SRC_N, SRC_NM1,
    SRC_S0, SRC_S1, SRC_S2,
    SRC_P0, SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5,
    SRC_M0, SRC_M1, SRC_M2, SRC_M3, SRC_M4, SRC_M5,
    SRC_A0, SRC_A1, SRC_A2, SRC_A3, SRC_A4, SRC_A5
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_M0, DST_M1, DST_M2, DST_M3, DST_M4, DST_M5,
    DST_A0, DST_A1, DST_A2, DST_A3, DST_A4, DST_A5,
    DST_DET, DST_DSC
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    logic clr;   // start from zero instead of the running sum
    logic sub;   // subtract the product
    dst_t dst;
  } mac_op_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_MAC_GO, BK_MAC_WAIT, BK_CHECK,
    BK_OUT_GO, BK_OUT_WAIT, BK_DIV_GO, BK_DIV_WAIT, BK_HOLD
  } bk_state_t;

  localparam int NUM_STEPS = 28;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  // M entries (00 01 02 11 12 22) = n*P - s_i*s_j, then adjugate, det, n*(n-1).
  localparam mac_op_t MAC_PROG [NUM_STEPS] = '{
    '{SRC_N,  SRC_P0, 1'b1, 1'b0, DST_NONE}, '{SRC_S0, SRC_S0, 1'b0, 1'b1, DST_M0},
    '{SRC_N,  SRC_P1, 1'b1, 1'b0, DST_NONE}, '{SRC_S0, SRC_S1, 1'b0, 1'b1, DST_M1},
    '{SRC_N,  SRC_P2, 1'b1, 1'b0, DST_NONE}, '{SRC_S0, SRC_S2, 1'b0, 1'b1, DST_M2},
    '{SRC_N,  SRC_P3, 1'b1, 1'b0, DST_NONE}, '{SRC_S1, SRC_S1, 1'b0, 1'b1, DST_M3},
    '{SRC_N,  SRC_P4, 1'b1, 1'b0, DST_NONE}, '{SRC_S1, SRC_S2, 1'b0, 1'b1, DST_M4},
    '{SRC_N,  SRC_P5, 1'b1, 1'b0, DST_NONE}, '{SRC_S2, SRC_S2, 1'b0, 1'b1, DST_M5},
    '{SRC_M3, SRC_M5, 1'b1, 1'b0, DST_NONE}, '{SRC_M4, SRC_M4, 1'b0, 1'b1, DST_A0},
    '{SRC_M2, SRC_M4, 1'b1, 1'b0, DST_NONE}, '{SRC_M1, SRC_M5, 1'b0, 1'b1, DST_A1},
    '{SRC_M1, SRC_M4, 1'b1, 1'b0, DST_NONE}, '{SRC_M2, SRC_M3, 1'b0, 1'b1, DST_A2},
    '{SRC_M0, SRC_M5, 1'b1, 1'b0, DST_NONE}, '{SRC_M2, SRC_M2, 1'b0, 1'b1, DST_A3},
    '{SRC_M1, SRC_M2, 1'b1, 1'b0, DST_NONE}, '{SRC_M0, SRC_M4, 1'b0, 1'b1, DST_A4},
    '{SRC_M0, SRC_M3, 1'b1, 1'b0, DST_NONE}, '{SRC_M1, SRC_M1, 1'b0, 1'b1, DST_A5},
    '{SRC_M0, SRC_A0, 1'b1, 1'b0, DST_NONE}, '{SRC_M1, SRC_A1, 1'b0, 1'b0, DST_NONE},
    '{SRC_M2, SRC_A2, 1'b0, 1'b0, DST_DET},
    '{SRC_N,  SRC_NM1, 1'b1, 1'b0, DST_DSC}
  };

  // Symmetric adjugate entry for a row and column.
  function automatic src_t adj_src(input logic [1:0] row, input logic [1:0] col);
    src_t s;
    case ({row, col})
      4'b0000:          s = SRC_A0;
      4'b0001, 4'b0100: s = SRC_A1;
      4'b0010, 4'b1000: s = SRC_A2;
      4'b0101:          s = SRC_A3;
      4'b0110, 4'b1001: s = SRC_A4;
      default:          s = SRC_A5;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ic3_if.sv -----
// Channel interfaces of inverse_covariance_3d: samples in, results out, config write.
// No dependencies.
`default_nettype none

interface ic3_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_a;
  logic signed [15:0] sample_b;
  logic signed [15:0] sample_c;
  logic               last;
  modport source (output valid, sample_a, sample_b, sample_c, last, input ready);
  modport sink   (input valid, sample_a, sample_b, sample_c, last, output ready);
endinterface

interface ic3_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic [1:0]         col_index;
  logic signed [63:0] entry_value;
  logic [1:0]         status;
  logic               final_result;
  modport source (output valid, row_index, col_index, entry_value, status, final_result,
                  input ready);
  modport sink   (input valid, row_index, col_index, entry_value, status, final_result,
                  output ready);
endinterface

interface ic3_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] out_frac_bits;
  modport source (output valid, out_frac_bits, input ready);
  modport sink   (input valid, out_frac_bits, output ready);
endinterface

`default_nettype wire

// ----- rtl/ic3_fifo.sv -----
// Small register queue carrying accumulator snapshots from front to back.
// Depends on nothing but its parameters.
`default_nettype none

module ic3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ic3_front.sv -----
// Sample accumulator: count, channel sums, cross-product sums; hands a snapshot on last.
// Depends on ic3_pkg and ic3_in_if.
`default_nettype none

module ic3_front import ic3_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES),
  localparam int PROD_W = 2 * SAMPLE_BITS + $clog2(MAX_SAMPLES),
  localparam int JOB_W  = CNT_W + 3 * SUM_W + 6 * PROD_W
) (
  input  logic             clk,
  input  logic             rst_n,
  ic3_in_if.sink           in_ch,
  output logic             job_valid,
  input  logic             job_ready,
  output logic [JOB_W-1:0] job_data
);
  // pair order aa ab ac bb bc cc
  localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]       sum_r [3];
  logic signed [SUM_W-1:0]       sum_nxt [3];
  logic signed [PROD_W-1:0]      psum_r [6];
  logic signed [PROD_W-1:0]      psum_nxt [6];
  logic signed [SAMPLE_BITS-1:0] x [3];
  logic signed [2*SAMPLE_BITS-1:0] prod [6];
  logic take, acc_en;

  assign x[0] = signed'(in_ch.sample_a[SAMPLE_BITS-1:0]);
  assign x[1] = signed'(in_ch.sample_b[SAMPLE_BITS-1:0]);
  assign x[2] = signed'(in_ch.sample_c[SAMPLE_BITS-1:0]);

  assign in_ch.ready = job_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign acc_en      = take && (cnt_r < CNT_W'(MAX_SAMPLES));
  assign job_valid   = take && in_ch.last;

  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(acc_en);
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = sum_r[i] + (acc_en ? SUM_W'(x[i]) : '0);
    end
    for (int k = 0; k < 6; k++) begin
      prod[k]     = x[PA[k]] * x[PB[k]];
      psum_nxt[k] = psum_r[k] + (acc_en ? PROD_W'(prod[k]) : '0);
    end
  end

  // snapshot includes the last sample itself, unless the count is already at MAX_SAMPLES
  always_comb begin
    job_data[CNT_W-1:0] = cnt_nxt;
    for (int i = 0; i < 3; i++) begin
      job_data[CNT_W + i*SUM_W +: SUM_W] = sum_nxt[i];
    end
    for (int k = 0; k < 6; k++) begin
      job_data[CNT_W + 3*SUM_W + k*PROD_W +: PROD_W] = psum_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
      for (int k = 0; k < 6; k++) psum_r[k] <= '0;
    end else if (take) begin
      if (in_ch.last) begin
        cnt_r <= '0;
        for (int i = 0; i < 3; i++) sum_r[i] <= '0;
        for (int k = 0; k < 6; k++) psum_r[k] <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        for (int i = 0; i < 3; i++) sum_r[i] <= sum_nxt[i];
        for (int k = 0; k < 6; k++) psum_r[k] <= psum_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ic3_mac.sv -----
// Shift-add multiply-accumulate, modulo 2^WIDE_BITS, one multiplier bit per cycle.
// Depends on ic3_pkg.
`default_nettype none

module ic3_mac import ic3_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  wide_t op_a,
  input  wide_t op_b,
  input  wide_t acc_init,
  input  logic  sub,
  output logic  busy,
  output logic  done,
  output wide_t result
);
  wide_t mcand_r, mplier_r, acc_r;
  logic  busy_r, done_r;

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = acc_r;

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= sub ? ('0 - op_a) : op_a;
      mplier_r <= op_b;
      acc_r    <= acc_init;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  // stops once either operand has run out of set bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (mplier_r == '0 || mcand_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ic3_div.sv -----
// Rounding divider: round(num/den), ties away from zero, den > 0, saturated to 64 bits.
// Restoring, one quotient bit per cycle. Depends on ic3_pkg.
`default_nettype none

module ic3_div import ic3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  wide_t              num,
  input  wide_t              den,
  output logic               done,
  output logic signed [63:0] quo
);
  localparam int CNT_W = $clog2(WIDE_BITS);

  wide_t            nn_r, dd_r, rem_r, q_r, mag, rem_sh;
  logic             neg_r, busy_r, done_r, ge, hi_nz;
  logic [CNT_W-1:0] cnt_r;
  logic [63:0]      u;

  assign mag    = num[WIDE_BITS-1] ? ('0 - num) : num;
  assign rem_sh = {rem_r[WIDE_BITS-2:0], nn_r[WIDE_BITS-1]};
  assign ge     = (rem_sh >= dd_r);
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[WIDE_BITS-1];
      nn_r  <= (mag << 1) + den;
      dd_r  <= den << 1;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - dd_r) : rem_sh;
      q_r   <= {q_r[WIDE_BITS-2:0], ge};
      nn_r  <= nn_r << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(WIDE_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // saturate the magnitude, then apply the sign
  always_comb begin
    hi_nz = |q_r[WIDE_BITS-1:64];
    u     = q_r[63:0];
    if (!neg_r) begin
      quo = (hi_nz || u[63]) ? 64'sh7FFF_FFFF_FFFF_FFFF : signed'(u);
    end else begin
      quo = (hi_nz || (u > 64'h8000_0000_0000_0000)) ? 64'sh8000_0000_0000_0000
                                                      : signed'(64'd0 - u);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ic3_back.sv -----
// Inversion sequencer: scatter matrix, adjugate, determinant, scaled rounded entries.
// Depends on ic3_pkg, ic3_out_if, ic3_mac, ic3_div and the assertion macros.
`default_nettype none

`include "inverse_covariance_3d_assert.svh"

module ic3_back import ic3_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES),
  localparam int PROD_W = 2 * SAMPLE_BITS + $clog2(MAX_SAMPLES),
  localparam int JOB_W  = CNT_W + 3 * SUM_W + 6 * PROD_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  logic [JOB_W-1:0]  job_data,
  input  logic [FRAC_W-1:0] frac_bits,
  ic3_out_if.source         out_ch
);
  bk_state_t state_r, state_nxt;

  logic [CNT_W-1:0]         n_r, job_n;
  logic signed [SUM_W-1:0]  s_r [3];
  logic signed [PROD_W-1:0] p_r [6];
  wide_t                    m_r [6];
  wide_t                    a_r [6];
  wide_t                    det_r, dsc_r;
  logic [STEP_W-1:0]        step_r;
  logic [1:0]               row_r, col_r;
  mac_op_t                  op;

  logic               out_valid_r, out_final_r;
  logic [1:0]         out_row_r, out_col_r;
  logic signed [63:0] out_value_r;
  status_t            out_status_r;

  logic               job_pop, few, pd, load_out;
  logic               mac_start, mac_sub, mac_busy, mac_done;
  wide_t              mac_a, mac_b, mac_init, mac_res;
  logic               div_start, div_done;
  logic signed [63:0] div_q;
  logic [FRAC_W-1:0]  f_eff;

  assign job_n     = job_data[CNT_W-1:0];
  assign few       = (job_n < CNT_W'(2));
  assign op        = MAC_PROG[step_r];
  assign job_ready = job_pop;
  assign f_eff     = (frac_bits > FRAC_MAX) ? FRAC_MAX : frac_bits;
  assign pd        = !m_r[0][WIDE_BITS-1] && (m_r[0] != '0) &&
                     !a_r[5][WIDE_BITS-1] && (a_r[5] != '0) &&
                     !det_r[WIDE_BITS-1]  && (det_r != '0);

  function automatic wide_t sx_sum(input logic signed [SUM_W-1:0] v);
    return {{(WIDE_BITS-SUM_W){v[SUM_W-1]}}, v};
  endfunction

  function automatic wide_t sx_prod(input logic signed [PROD_W-1:0] v);
    return {{(WIDE_BITS-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic wide_t sel_src(input src_t s);
    wide_t v;
    case (s)
      SRC_N:   v = {{(WIDE_BITS-CNT_W){1'b0}}, n_r};
      SRC_NM1: v = {{(WIDE_BITS-CNT_W){1'b0}}, n_r - 1'b1};
      SRC_S0:  v = sx_sum(s_r[0]);
      SRC_S1:  v = sx_sum(s_r[1]);
      SRC_S2:  v = sx_sum(s_r[2]);
      SRC_P0:  v = sx_prod(p_r[0]);
      SRC_P1:  v = sx_prod(p_r[1]);
      SRC_P2:  v = sx_prod(p_r[2]);
      SRC_P3:  v = sx_prod(p_r[3]);
      SRC_P4:  v = sx_prod(p_r[4]);
      SRC_P5:  v = sx_prod(p_r[5]);
      SRC_M0:  v = m_r[0];
      SRC_M1:  v = m_r[1];
      SRC_M2:  v = m_r[2];
      SRC_M3:  v = m_r[3];
      SRC_M4:  v = m_r[4];
      SRC_M5:  v = m_r[5];
      SRC_A0:  v = a_r[0];
      SRC_A1:  v = a_r[1];
      SRC_A2:  v = a_r[2];
      SRC_A3:  v = a_r[3];
      SRC_A4:  v = a_r[4];
      SRC_A5:  v = a_r[5];
      default: v = '0;
    endcase
    return v;
  endfunction

  ic3_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mac_start),
    .op_a     (mac_a),
    .op_b     (mac_b),
    .acc_init (mac_init),
    .sub      (mac_sub),
    .busy     (mac_busy),
    .done     (mac_done),
    .result   (mac_res)
  );

  ic3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mac_res),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    mac_start = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    mac_a     = sel_src(op.a);
    mac_b     = sel_src(op.b);
    mac_init  = op.clr ? '0 : mac_res;
    mac_sub   = op.sub;
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          load_out  = few;
          state_nxt = few ? BK_HOLD : BK_MAC_GO;
        end
      end
      BK_MAC_GO: begin
        mac_start = 1'b1;
        state_nxt = BK_MAC_WAIT;
      end
      BK_MAC_WAIT: begin
        if (mac_done) begin
          state_nxt = (step_r == STEP_W'(NUM_STEPS - 1)) ? BK_CHECK : BK_MAC_GO;
        end
      end
      BK_CHECK: begin
        load_out  = !pd;
        state_nxt = pd ? BK_OUT_GO : BK_HOLD;
      end
      BK_OUT_GO: begin
        mac_a     = sel_src(adj_src(row_r, col_r));
        mac_b     = dsc_r;
        mac_init  = '0;
        mac_sub   = 1'b0;
        mac_start = 1'b1;
        state_nxt = BK_OUT_WAIT;
      end
      BK_OUT_WAIT: begin
        if (mac_done) state_nxt = BK_DIV_GO;
      end
      BK_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = BK_DIV_WAIT;
      end
      BK_DIV_WAIT: begin
        if (div_done) begin
          load_out  = 1'b1;
          state_nxt = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_valid_r && out_ch.ready) begin
          state_nxt = out_final_r ? BK_IDLE : BK_OUT_GO;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          n_r <= job_n;
          for (int i = 0; i < 3; i++) s_r[i] <= job_data[CNT_W + i*SUM_W +: SUM_W];
          for (int k = 0; k < 6; k++) begin
            p_r[k] <= job_data[CNT_W + 3*SUM_W + k*PROD_W +: PROD_W];
          end
          step_r <= '0;
          row_r  <= '0;
          col_r  <= '0;
          if (few) begin
            out_row_r    <= '0;
            out_col_r    <= '0;
            out_value_r  <= '0;
            out_status_r <= ST_FEW;
            out_final_r  <= 1'b1;
          end
        end
      end
      BK_MAC_WAIT: begin
        if (mac_done) begin
          step_r <= step_r + 1'b1;
          case (op.dst)
            DST_M0:  m_r[0] <= mac_res;
            DST_M1:  m_r[1] <= mac_res;
            DST_M2:  m_r[2] <= mac_res;
            DST_M3:  m_r[3] <= mac_res;
            DST_M4:  m_r[4] <= mac_res;
            DST_M5:  m_r[5] <= mac_res;
            DST_A0:  a_r[0] <= mac_res;
            DST_A1:  a_r[1] <= mac_res;
            DST_A2:  a_r[2] <= mac_res;
            DST_A3:  a_r[3] <= mac_res;
            DST_A4:  a_r[4] <= mac_res;
            DST_A5:  a_r[5] <= mac_res;
            DST_DET: det_r  <= mac_res;
            DST_DSC: dsc_r  <= mac_res;
            default: ;
          endcase
        end
      end
      BK_CHECK: begin
        if (pd) begin
          dsc_r <= dsc_r << f_eff;   // n(n-1) * 2^f
        end else begin
          out_row_r    <= '0;
          out_col_r    <= '0;
          out_value_r  <= '0;
          out_status_r <= ST_NOT_PD;
          out_final_r  <= 1'b1;
        end
      end
      BK_DIV_WAIT: begin
        if (div_done) begin
          out_row_r    <= row_r;
          out_col_r    <= col_r;
          out_value_r  <= div_q;
          out_status_r <= ST_OK;
          out_final_r  <= (row_r == 2'd2) && (col_r == 2'd2);
        end
      end
      BK_HOLD: begin
        if (out_valid_r && out_ch.ready && !out_final_r) begin
          if (col_r == 2'd2) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.row_index    = out_row_r;
  assign out_ch.col_index    = out_col_r;
  assign out_ch.entry_value  = out_value_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.final_result = out_final_r;

  `IC3_ASSERT_HOLDS(a_status_single, out_valid_r && out_status_r != ST_OK, out_final_r && out_row_r == 2'd0 && out_col_r == 2'd0 && out_value_r == '0, "status result must stand alone")
  `IC3_ASSERT_NEXT(a_final_idle, out_valid_r && out_ch.ready && out_final_r, state_r == BK_IDLE, "sequencer not idle after final result")
  `IC3_ASSERT_HOLDS(a_mac_free, mac_start, !mac_busy, "multiplier started while busy")
  `IC3_ASSERT_HOLDS(a_pop_clear, job_pop, !out_valid_r, "new request taken with a result pending")

endmodule

`default_nettype wire

// ----- rtl/inverse_covariance_3d.sv -----
// Top level of inverse_covariance_3d: front accumulator, snapshot queue, inversion back end.
// Depends on ic3_pkg, ic3_if, ic3_front, ic3_fifo, ic3_back.
//
//   channel  dir  handshake           payload
//   in_ch    in   valid/ready         sample_a, sample_b, sample_c, last
//   out_ch   out  valid/ready         row_index, col_index, entry_value, status, final_result
//   cfg_ch   in   valid/ready(=1)     out_frac_bits
//
// A sample request is taken every cycle while the queue has room; a last-marked one
// pushes the running count and sums into a two-deep queue and clears the accumulators.
// The back end steps the shift-add multiplier through the multiplier bits (at most 256)
// until either operand runs out of set bits, on each of 28 setup products and 9 entry
// products, and runs a restoring division per entry.
// Input stalls only while two finished sets wait in the queue.
// Reset is synchronous, active low; no memory clearing pass.
`default_nettype none

module inverse_covariance_3d import ic3_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  ic3_in_if.sink     in_ch,
  ic3_out_if.source  out_ch,
  ic3_cfg_if.sink    cfg_ch
);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
  localparam int PROD_W = 2 * SAMPLE_BITS + $clog2(MAX_SAMPLES);
  localparam int JOB_W  = CNT_W + 3 * SUM_W + 6 * PROD_W;

  logic [FRAC_W-1:0] frac_r;
  logic              fj_valid, fj_ready, bj_valid, bj_ready;
  logic [JOB_W-1:0]  fj_data, bj_data;

  // config register, always writable
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r <= FRAC_RESET;
    end else if (cfg_ch.valid) begin
      frac_r <= cfg_ch.out_frac_bits;
    end
  end

  ic3_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job_data  (fj_data)
  );

  // snapshot queue lets the accumulator run ahead of a busy back end
  ic3_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  (fj_data),
    .rd_valid (bj_valid),
    .rd_ready (bj_ready),
    .rd_data  (bj_data)
  );

  ic3_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job_data  (bj_data),
    .frac_bits (frac_r),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
